// File: hw/rtl/qknob_pkg.sv
// ----------------------------------------------------------------------------
// qknob_pkg
// Shared types and constants for the quadrature knob with press timing.
// ----------------------------------------------------------------------------
package qknob_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CHG_W      = 3;
    localparam int DETENT_W   = 4;
    localparam int TICKS_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DETENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG   = 2'd1;

    localparam logic [DETENT_W-1:0] DETENT_RESET = 4'd4;
    localparam logic [DETENT_W-1:0] DETENT_MAX   = 4'd8;
    localparam logic [TICKS_W-1:0]  LONG_RESET   = 16'd250;

    // next phase state for a forward and a reverse Gray step
    localparam logic [1:0] FWD_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
    localparam logic [1:0] REV_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

    typedef struct packed {
        logic up;
        logic down;
    } t_rot_ev;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_press_ev;

endpackage

// File: hw/rtl/quadrature_knob_with_press_timing_top.sv
// ----------------------------------------------------------------------------
// quadrature_knob_with_press_timing_top
// Poll-tick decoder for a quadrature knob with a push button.
// ----------------------------------------------------------------------------
// Each request is one poll tick and yields exactly one result. The block
// takes one request per clock cycle while the result register is not stalled;
// a result passes through the input register, then the result register. The
// phase and hold counters update once per accepted request, and a
// stalled result register holds both stages in place.
module quadrature_knob_with_press_timing_top
    import qknob_pkg::*;
#(
    parameter int HOLD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] phase_a, [1] phase_b, [2] button_down, [7:3] zero
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] step_up, [1] step_down, [2] short_press, [3] long_press, [7:4] zero
    output logic [7:0]            m_axis_tdata
);

    logic [DETENT_W-1:0] r_detent;
    logic [TICKS_W-1:0]  r_long;
    logic                r_in_valid;
    logic [1:0]          r_in_phases;
    logic                r_in_button;
    logic                r_out_valid;
    logic [3:0]          r_out_data;
    logic                w_adv;
    logic                w_step;
    t_rot_ev             w_rot;
    t_press_ev           w_press;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_step        = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent <= DETENT_RESET;
            r_long   <= LONG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_DETENT) begin
                r_detent <= i_cfg_data[DETENT_W-1:0];
            end else if (i_cfg_index == CFG_IDX_LONG) begin
                r_long <= i_cfg_data[TICKS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_phases <= {s_axis_tdata[0], s_axis_tdata[1]};
            r_in_button <= s_axis_tdata[2];
        end
    end

    qknob_rotary u_rotary (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_step),
        .i_phases (r_in_phases),
        .i_detent (r_detent),
        .o_ev     (w_rot)
    );

    qknob_press #(
        .HOLD_BITS (HOLD_BITS)
    ) u_press (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_step),
        .i_button     (r_in_button),
        .i_long_ticks (r_long),
        .o_ev         (w_press)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {w_press.long_press, w_press.short_press, w_rot.down, w_rot.up};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data};

endmodule

// File: hw/rtl/qknob_rotary.sv
// ----------------------------------------------------------------------------
// qknob_rotary
// Phase tracking, detent change counter and Gray step judgment.
// ----------------------------------------------------------------------------
module qknob_rotary
    import qknob_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [1:0]          i_phases,
    input  logic [DETENT_W-1:0] i_detent,
    output t_rot_ev             o_ev
);

    logic [1:0]       r_last, n_last;
    logic [CHG_W-1:0] r_cnt, n_cnt;
    logic [CHG_W-1:0] w_tgt_m1;
    logic             w_change;
    logic             w_judge;

    always_comb begin
        if (i_detent == '0) begin
            w_tgt_m1 = '0;
        end else if (i_detent > DETENT_MAX) begin
            w_tgt_m1 = CHG_W'(DETENT_MAX - 4'd1);
        end else begin
            w_tgt_m1 = CHG_W'(i_detent - 4'd1);
        end
    end

    assign w_change = (i_phases != r_last);
    assign w_judge  = w_change && (r_cnt >= w_tgt_m1);

    always_comb begin
        n_last    = r_last;
        n_cnt     = r_cnt;
        o_ev.up   = 1'b0;
        o_ev.down = 1'b0;
        if (w_change) begin
            n_last = i_phases;
            if (w_judge) begin
                n_cnt = '0;
                if (i_phases == FWD_NEXT[r_last]) begin
                    o_ev.down = 1'b1;
                end else if (i_phases == REV_NEXT[r_last]) begin
                    o_ev.up = 1'b1;
                end
            end else begin
                n_cnt = r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_cnt  <= '0;
        end else if (i_en) begin
            r_last <= n_last;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/qknob_press.sv
// ----------------------------------------------------------------------------
// qknob_press
// Saturating hold counter and short/long press classification on release.
// ----------------------------------------------------------------------------
module qknob_press
    import qknob_pkg::*;
#(
    parameter int HOLD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_button,
    input  logic [TICKS_W-1:0] i_long_ticks,
    output t_press_ev          o_ev
);

    localparam int CMP_W = (HOLD_BITS > TICKS_W) ? HOLD_BITS : TICKS_W;

    logic [HOLD_BITS-1:0] r_hold, n_hold;
    logic                 w_below;

    assign w_below = CMP_W'(r_hold) < CMP_W'(i_long_ticks);

    always_comb begin
        n_hold           = r_hold;
        o_ev.short_press = 1'b0;
        o_ev.long_press  = 1'b0;
        if (i_button) begin
            if (!(&r_hold)) begin
                n_hold = r_hold + 1'b1;
            end
        end else begin
            n_hold = '0;
            if (r_hold != '0) begin
                o_ev.short_press = w_below;
                o_ev.long_press  = !w_below;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (i_en) begin
            r_hold <= n_hold;
        end
    end

endmodule

// File: hw/rtl/qknob_checker.sv
// ----------------------------------------------------------------------------
// qknob_checker
// Port-level checks for the quadrature knob with press timing.
// ----------------------------------------------------------------------------
module qknob_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("step_up and step_down together");

    a_press_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
        else $error("short_press and long_press together");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request stalled with empty result register");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind quadrature_knob_with_press_timing_top qknob_checker u_qknob_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadrature knob with press timing. Poll ticks
// go in on the request stream; each result is compared with the value given
// by its directed table row, if any, else with an in-bench decoder of
// rotation steps and press lengths. The run has two parts: a directed table,
// then random phases at several register settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import qknob_pkg::*;

    localparam int HOLD_BITS       = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 156;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam int PHASE_DETENT [RAND_PHASES] = '{1, 8, 2, 3, 4, 6, 5, 7};
    localparam int PHASE_LONG   [RAND_PHASES] = '{1, 2, 10, 40, 65535, 17, 25, 0};
    localparam int SEND_IDLE    [4]           = '{0, 80, 0, 23};
    localparam int RECV_STALL   [4]           = '{0, 0, 80, 23};

    typedef struct packed {
        logic long_press;
        logic short_press;
        logic step_down;
        logic step_up;
    } t_knob_ev;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [2:0]            tick;   // [0] phase_a, [1] phase_b, [2] button_down
        logic                  typed;
        t_knob_ev              ev;
    } t_stim_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;

    int unsigned cycle_cnt      = 0;
    int          fail_cnt       = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          press_span     = 20;

    t_knob_ev  expected_q [$];
    t_stim_row stim_table [$];

    // decoder state and registers
    logic [DETENT_W-1:0]  detent_reg = DETENT_RESET;
    logic [TICKS_W-1:0]   long_reg   = LONG_RESET;
    logic [1:0]           last_ph    = '0;
    logic [CHG_W-1:0]     chg_cnt    = '0;
    logic [HOLD_BITS-1:0] hold_cnt   = '0;

    // random tick generator state
    logic [1:0] gen_ph       = '0;
    logic       gen_dir      = 1'b0;
    logic       gen_btn      = 1'b0;
    int         gen_btn_left = 0;

    quadrature_knob_with_press_timing_top #(
        .HOLD_BITS(HOLD_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_knob_ev decode_tick(input logic [2:0] tick);
        t_knob_ev            ev;
        logic [1:0]          now_ph;
        logic [DETENT_W-1:0] tgt;
        ev     = '0;
        now_ph = {tick[0], tick[1]};
        tgt    = detent_reg;
        if (tgt == '0) tgt = 4'd1;
        if (tgt > DETENT_MAX) tgt = DETENT_MAX;
        if (now_ph != last_ph) begin
            if (chg_cnt >= tgt - 1'b1) begin
                if (now_ph == FWD_NEXT[last_ph]) begin
                    ev.step_down = 1'b1;
                end else if (now_ph == REV_NEXT[last_ph]) begin
                    ev.step_up = 1'b1;
                end
                chg_cnt = '0;
            end else begin
                chg_cnt = chg_cnt + 1'b1;
            end
            last_ph = now_ph;
        end
        if (tick[2]) begin
            if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
        end else begin
            if (hold_cnt != '0) begin
                if (32'(hold_cnt) < 32'(long_reg)) ev.short_press = 1'b1;
                else ev.long_press = 1'b1;
            end
            hold_cnt = '0;
        end
        return ev;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void add_tick(input logic a, input logic b, input logic btn);
        t_stim_row row;
        row       = '{ROW_TICK, '0, '0, {btn, b, a}, 1'b0, '0};
        stim_table.push_back(row);
    endfunction

    function automatic void add_tick_exp(input logic a, input logic b, input logic btn,
                                         input t_knob_ev ev);
        t_stim_row row;
        row       = '{ROW_TICK, '0, '0, {btn, b, a}, 1'b1, ev};
        stim_table.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row       = '{ROW_CFG, idx, data, 3'b000, 1'b0, '0};
        stim_table.push_back(row);
    endfunction

    task automatic push_tick(input logic [2:0] tick, input logic typed, input t_knob_ev typed_ev);
        int       gap;
        t_knob_ev ev;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        ev = decode_tick(tick);
        expected_q.push_back(typed ? typed_ev : ev);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_DETENT) detent_reg = data[DETENT_W-1:0];
        else if (idx == CFG_IDX_LONG) long_reg = data[TICKS_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic next_gen_tick(output logic [2:0] tick);
        int r;
        if (gen_btn_left == 0) begin
            gen_btn      = ~gen_btn;
            gen_btn_left = gen_btn ? $urandom_range(press_span, 1) : $urandom_range(6, 1);
        end
        gen_btn_left--;
        if ($urandom_range(19) == 0) gen_dir = ~gen_dir;
        r = $urandom_range(99);
        if (r < 10) begin
            gen_ph = 2'($urandom_range(3));
        end else if (r >= 35) begin
            gen_ph = gen_dir ? REV_NEXT[gen_ph] : FWD_NEXT[gen_ph];
        end
        tick = {gen_btn, gen_ph[0], gen_ph[1]};
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_knob_ev want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("result %h with no request waiting", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("step_up",     want.step_up,     m_axis_tdata[0]);
                check_field("step_down",   want.step_down,   m_axis_tdata[1]);
                check_field("short_press", want.short_press, m_axis_tdata[2]);
                check_field("long_press",  want.long_press,  m_axis_tdata[3]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [2:0] tick;
        int         mode;
        int         long_val;
        int         detent_val;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_tick_exp(0, 0, 0, '0);
        add_tick(1, 1, 1);
        add_tick(0, 0, 0);
        add_cfg(CFG_IDX_DETENT, 16'd1);
        add_tick_exp(1, 0, 0, '{1'b0, 1'b0, 1'b1, 1'b0});
        add_tick(1, 1, 0);
        add_tick(0, 1, 0);
        add_tick(0, 0, 0);
        add_tick(0, 1, 0);
        add_tick(1, 1, 0);
        add_tick(0, 0, 0);
        add_tick(0, 0, 1);
        add_tick_exp(0, 0, 0, '{1'b0, 1'b1, 1'b0, 1'b0});
        add_cfg(CFG_IDX_LONG, 16'd0);
        add_tick(0, 0, 1);
        add_tick_exp(0, 0, 0, '{1'b1, 1'b0, 1'b0, 1'b0});
        add_cfg(CFG_IDX_DETENT, 16'd0);
        add_tick(1, 0, 0);
        add_cfg(CFG_IDX_DETENT, 16'hFFFF);
        add_cfg(CFG_IDX_SPARE_A, 16'h0003);
        add_cfg(CFG_IDX_SPARE_B, 16'hFFFF);
        add_tick(0, 0, 0);
        add_tick(1, 0, 0);
        add_tick(0, 0, 0);
        add_tick(1, 0, 0);
        add_tick(0, 0, 0);
        add_cfg(CFG_IDX_DETENT, 16'd2);
        add_tick(0, 1, 0);

        send_idle_pct  = SEND_IDLE[3];
        recv_stall_pct = RECV_STALL[3];
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                drain();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end else begin
                push_tick(stim_table[i].tick, stim_table[i].typed, stim_table[i].ev);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            detent_val = PHASE_DETENT[p];
            long_val   = PHASE_LONG[p];
            if (p == 5) begin
                detent_val = $urandom_range(15);
                long_val   = $urandom_range(30, 1);
            end
            write_reg(CFG_IDX_DETENT, 16'(detent_val));
            write_reg(CFG_IDX_LONG, 16'(long_val));
            press_span = (long_val == 0) ? 20 : ((2 * long_val + 2 > 120) ? 120 : 2 * long_val + 2);
            mode           = p % 4;
            send_idle_pct  = SEND_IDLE[mode];
            recv_stall_pct = RECV_STALL[mode];
            gen_ph         = last_ph;
            repeat (ITEMS_PER_PHASE) begin
                next_gen_tick(tick);
                push_tick(tick, 1'b0, '0);
            end
        end

        drain();
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: quadrature_knob_with_press_timing_top.f
hw/rtl/qknob_pkg.sv
hw/rtl/qknob_rotary.sv
hw/rtl/qknob_press.sv
hw/rtl/quadrature_knob_with_press_timing_top.sv
hw/rtl/qknob_checker.sv
dv/testbench.sv
